// File: hdl/ascp_pkg.sv
// ----------------------------------------------------------------------------
// ascp_pkg
// Shared constants, types and prefix character lookups for the ASCII setting
// command parser.
// ----------------------------------------------------------------------------
package ascp_pkg;

  localparam int LINE_LEN        = 64;
  localparam int POS_W           = $clog2(LINE_LEN);
  localparam int FREQ_PREFIX_LEN = 17;
  localparam int MODE_PREFIX_LEN = 12;
  localparam int FREQ_MAX        = 10000;
  localparam int MODE_MAX        = 3;
  localparam int VALUE_SAT       = 10001;
  localparam int VAL_W           = 14;
  localparam int ACC_W           = 18;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // number scan phases
  localparam logic [1:0] PH_BLANK  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_FREQ_SET  = 3'd0;
  localparam logic [2:0] ST_MODE_SET  = 3'd1;
  localparam logic [2:0] ST_BAD_FREQ  = 3'd2;
  localparam logic [2:0] ST_BAD_MODE  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  typedef struct packed {
    logic             valid;
    logic [2:0]       status;
    logic [VAL_W-1:0] frequency;
    logic [1:0]       mode;
  } result_t;

  function automatic logic [7:0] freq_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "T";
      5'd1:    c = "a";
      5'd2:    c = "r";
      5'd3:    c = "g";
      5'd4:    c = "e";
      5'd5:    c = "t";
      5'd6:    c = " ";
      5'd7:    c = "F";
      5'd8:    c = "r";
      5'd9:    c = "e";
      5'd10:   c = "q";
      5'd11:   c = "u";
      5'd12:   c = "e";
      5'd13:   c = "n";
      5'd14:   c = "c";
      5'd15:   c = "y";
      5'd16:   c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] mode_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "O";
      5'd1:    c = "u";
      5'd2:    c = "t";
      5'd3:    c = "p";
      5'd4:    c = "u";
      5'd5:    c = "t";
      5'd6:    c = " ";
      5'd7:    c = "M";
      5'd8:    c = "o";
      5'd9:    c = "d";
      5'd10:   c = "e";
      5'd11:   c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/ascp_line_core.sv
// ----------------------------------------------------------------------------
// ascp_line_core
// Line state, prefix match and atoi-style number scan. Updates the setting
// registers and forms the result for one character per fire.
// ----------------------------------------------------------------------------
module ascp_line_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             rx_char,
  output ascp_pkg::result_t      res
);

  logic [ascp_pkg::VAL_W-1:0] target_frequency, target_frequency_next;
  logic [1:0]                 output_select, output_select_next;
  logic [ascp_pkg::POS_W-1:0] char_position, char_position_next;
  logic                       freq_prefix_ok, freq_prefix_ok_next;
  logic                       mode_prefix_ok, mode_prefix_ok_next;
  logic [1:0]                 number_phase, number_phase_next;
  logic                       number_negative, number_negative_next;
  logic [ascp_pkg::VAL_W-1:0] number_value, number_value_next;

  logic                       is_term, is_digit, is_blank, is_sign;
  logic                       freq_line, mode_line, feed, neg_nonzero, overflow;
  logic [ascp_pkg::ACC_W-1:0] acc;
  logic [ascp_pkg::VAL_W-1:0] acc_sat;

  assign is_term  = (rx_char == ascp_pkg::CH_LF) || (rx_char == ascp_pkg::CH_CR);
  assign is_digit = (rx_char >= ascp_pkg::CH_ZERO) && (rx_char <= ascp_pkg::CH_NINE);
  assign is_blank = (rx_char == ascp_pkg::CH_TAB) || (rx_char == ascp_pkg::CH_VT) ||
                    (rx_char == ascp_pkg::CH_FF) || (rx_char == ascp_pkg::CH_SPACE);
  assign is_sign  = (rx_char == ascp_pkg::CH_PLUS) || (rx_char == ascp_pkg::CH_MINUS);

  assign freq_line = freq_prefix_ok &&
                     (char_position >= ascp_pkg::POS_W'(ascp_pkg::FREQ_PREFIX_LEN));
  assign mode_line = mode_prefix_ok &&
                     (char_position >= ascp_pkg::POS_W'(ascp_pkg::MODE_PREFIX_LEN));
  // prefixes differ in the first character, so at most one line kind feeds
  assign feed      = freq_line || mode_line;
  assign overflow  = (char_position == ascp_pkg::POS_W'(ascp_pkg::LINE_LEN - 1));
  assign neg_nonzero = number_negative && (number_value != '0);

  // value * 10 + digit, saturated
  assign acc = (ascp_pkg::ACC_W'(number_value) << 3) + (ascp_pkg::ACC_W'(number_value) << 1)
             + ascp_pkg::ACC_W'(rx_char - ascp_pkg::CH_ZERO);
  assign acc_sat = (acc > ascp_pkg::ACC_W'(ascp_pkg::VALUE_SAT)) ?
                   ascp_pkg::VAL_W'(ascp_pkg::VALUE_SAT) : acc[ascp_pkg::VAL_W-1:0];

  always_comb begin
    target_frequency_next = target_frequency;
    output_select_next    = output_select;
    char_position_next    = char_position;
    freq_prefix_ok_next   = freq_prefix_ok;
    mode_prefix_ok_next   = mode_prefix_ok;
    number_phase_next     = number_phase;
    number_negative_next  = number_negative;
    number_value_next     = number_value;
    res.valid             = 1'b0;
    res.status            = ascp_pkg::ST_UNKNOWN;

    if (is_term) begin
      res.valid = 1'b1;
      if (freq_line) begin
        if (!neg_nonzero && (number_value <= ascp_pkg::VAL_W'(ascp_pkg::FREQ_MAX))) begin
          target_frequency_next = number_value;
          res.status            = ascp_pkg::ST_FREQ_SET;
        end else begin
          res.status = ascp_pkg::ST_BAD_FREQ;
        end
      end else if (mode_line) begin
        if (!number_negative && (number_value >= ascp_pkg::VAL_W'(1)) &&
            (number_value <= ascp_pkg::VAL_W'(ascp_pkg::MODE_MAX))) begin
          output_select_next = number_value[1:0];
          res.status         = ascp_pkg::ST_MODE_SET;
        end else begin
          res.status = ascp_pkg::ST_BAD_MODE;
        end
      end else begin
        res.status = ascp_pkg::ST_UNKNOWN;
      end
    end else begin
      if (char_position < ascp_pkg::POS_W'(ascp_pkg::FREQ_PREFIX_LEN)) begin
        if (rx_char != ascp_pkg::freq_char(char_position[4:0])) begin
          freq_prefix_ok_next = 1'b0;
        end
      end
      if (char_position < ascp_pkg::POS_W'(ascp_pkg::MODE_PREFIX_LEN)) begin
        if (rx_char != ascp_pkg::mode_char(char_position[4:0])) begin
          mode_prefix_ok_next = 1'b0;
        end
      end
      if (feed) begin
        case (number_phase)
          ascp_pkg::PH_BLANK: begin
            if (is_blank) begin
              number_phase_next = ascp_pkg::PH_BLANK;
            end else if (is_sign) begin
              number_negative_next = (rx_char == ascp_pkg::CH_MINUS);
              number_phase_next    = ascp_pkg::PH_DIGITS;
            end else if (is_digit) begin
              number_phase_next = ascp_pkg::PH_DIGITS;
              number_value_next = acc_sat;
            end else begin
              number_phase_next = ascp_pkg::PH_DONE;
            end
          end
          ascp_pkg::PH_DIGITS: begin
            if (is_digit) begin
              number_value_next = acc_sat;
            end else begin
              number_phase_next = ascp_pkg::PH_DONE;
            end
          end
          default: begin
            number_phase_next = number_phase;
          end
        endcase
      end
      char_position_next = char_position + ascp_pkg::POS_W'(1);
      if (overflow) begin
        res.valid  = 1'b1;
        res.status = ascp_pkg::ST_TOO_LONG;
      end
    end

    // a status ends the line
    if (res.valid) begin
      char_position_next   = '0;
      freq_prefix_ok_next  = 1'b1;
      mode_prefix_ok_next  = 1'b1;
      number_phase_next    = ascp_pkg::PH_BLANK;
      number_negative_next = 1'b0;
      number_value_next    = '0;
    end

    res.frequency = target_frequency_next;
    res.mode      = output_select_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_frequency <= '0;
      output_select    <= '0;
      char_position    <= '0;
      freq_prefix_ok   <= 1'b1;
      mode_prefix_ok   <= 1'b1;
      number_phase     <= ascp_pkg::PH_BLANK;
      number_negative  <= 1'b0;
      number_value     <= '0;
    end else if (fire) begin
      target_frequency <= target_frequency_next;
      output_select    <= output_select_next;
      char_position    <= char_position_next;
      freq_prefix_ok   <= freq_prefix_ok_next;
      mode_prefix_ok   <= mode_prefix_ok_next;
      number_phase     <= number_phase_next;
      number_negative  <= number_negative_next;
      number_value     <= number_value_next;
    end
  end

endmodule

// File: hdl/ascii_setting_command_parser.sv
// ----------------------------------------------------------------------------
// ascii_setting_command_parser
// Parses "Target Frequency <n>" and "Output Mode <n>" command lines from a
// received character stream and reports one status per line.
//
// One character is taken per clock while the result side keeps up; a status
// item is offered once the terminating CR or LF has gone from the input
// register through the single parse pass into the result register, which
// may wait on a stalled status. Overlong lines give a too-long status on
// the 64th character without a terminator, which is dropped. frequency and
// mode show the setting registers as they stand after the reported line.
// ----------------------------------------------------------------------------
module ascii_setting_command_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [13:0] frequency,
  output logic [1:0]  mode
);

  logic              s1_valid;
  logic [7:0]        s1_char;
  logic              fire;
  logic              in_take;
  ascp_pkg::result_t res;

  // the parse stage moves when the result register is free or being drained
  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  ascp_line_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_char (s1_char),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      status    <= res.status;
      frequency <= res.frequency;
      mode      <= res.mode;
    end
  end

endmodule

// File: tb/ascp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascp_checker
// Watches both channels of the command parser, replays every accepted
// character through its own line parser and compares each status item with
// the oldest one due.
// ----------------------------------------------------------------------------
module ascp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [13:0] frequency,
  input  logic [1:0]  mode,
  output int          fail_count,
  output int          pending,
  output int          bytes_taken,
  output int          results_seen
);

  typedef struct packed {
    logic [2:0]                 st;
    logic [ascp_pkg::VAL_W-1:0] freq;
    logic [1:0]                 md;
  } line_status_t;

  localparam logic [8*ascp_pkg::FREQ_PREFIX_LEN-1:0] FREQ_WORD = "Target Frequency ";
  localparam logic [8*ascp_pkg::MODE_PREFIX_LEN-1:0] MODE_WORD = "Output Mode ";

  line_status_t               due_status_q[$];
  logic [ascp_pkg::VAL_W-1:0] tgt_freq;
  logic [1:0]                 out_sel;
  int                         pos;
  logic                       freq_ok;
  logic                       mode_ok;
  logic [1:0]                 num_phase;
  logic                       num_neg;
  int                         num_mag;
  int                         errs;
  int                         taken;
  int                         checked;

  function automatic void clear_line();
    pos       = 0;
    freq_ok   = 1'b1;
    mode_ok   = 1'b1;
    num_phase = ascp_pkg::PH_BLANK;
    num_neg   = 1'b0;
    num_mag   = 0;
  endfunction

  // atoi-style scan of the characters after a matched prefix
  task automatic scan_number(input logic [7:0] c);
    logic digit;
    digit = (c >= ascp_pkg::CH_ZERO) && (c <= ascp_pkg::CH_NINE);
    if (num_phase == ascp_pkg::PH_BLANK) begin
      if (c == ascp_pkg::CH_TAB || c == ascp_pkg::CH_VT || c == ascp_pkg::CH_FF ||
          c == ascp_pkg::CH_SPACE) return;
      if (c == ascp_pkg::CH_PLUS || c == ascp_pkg::CH_MINUS) begin
        num_neg   = (c == ascp_pkg::CH_MINUS);
        num_phase = ascp_pkg::PH_DIGITS;
        return;
      end
      if (!digit) begin
        num_phase = ascp_pkg::PH_DONE;
        return;
      end
      num_phase = ascp_pkg::PH_DIGITS;
    end else if (num_phase != ascp_pkg::PH_DIGITS) begin
      return;
    end
    if (!digit) begin
      num_phase = ascp_pkg::PH_DONE;
      return;
    end
    num_mag = num_mag * 10 + int'(c - ascp_pkg::CH_ZERO);
    if (num_mag > ascp_pkg::VALUE_SAT) num_mag = ascp_pkg::VALUE_SAT;
  endtask

  task automatic parse_char(input logic [7:0] c);
    line_status_t r;
    logic         neg_nonzero;
    if (c == ascp_pkg::CH_LF || c == ascp_pkg::CH_CR) begin
      neg_nonzero = num_neg && (num_mag != 0);
      if (freq_ok && pos >= ascp_pkg::FREQ_PREFIX_LEN) begin
        if (!neg_nonzero && num_mag <= ascp_pkg::FREQ_MAX) begin
          tgt_freq = ascp_pkg::VAL_W'(num_mag);
          r.st     = ascp_pkg::ST_FREQ_SET;
        end else begin
          r.st = ascp_pkg::ST_BAD_FREQ;
        end
      end else if (mode_ok && pos >= ascp_pkg::MODE_PREFIX_LEN) begin
        if (!num_neg && num_mag >= 1 && num_mag <= ascp_pkg::MODE_MAX) begin
          out_sel = 2'(num_mag);
          r.st    = ascp_pkg::ST_MODE_SET;
        end else begin
          r.st = ascp_pkg::ST_BAD_MODE;
        end
      end else begin
        r.st = ascp_pkg::ST_UNKNOWN;
      end
      clear_line();
      r.freq = tgt_freq;
      r.md   = out_sel;
      due_status_q.push_back(r);
    end else begin
      if (pos < ascp_pkg::FREQ_PREFIX_LEN) begin
        if (c != FREQ_WORD[8*(ascp_pkg::FREQ_PREFIX_LEN-1-pos) +: 8]) freq_ok = 1'b0;
      end else if (freq_ok) begin
        scan_number(c);
      end
      if (pos < ascp_pkg::MODE_PREFIX_LEN) begin
        if (c != MODE_WORD[8*(ascp_pkg::MODE_PREFIX_LEN-1-pos) +: 8]) mode_ok = 1'b0;
      end else if (mode_ok) begin
        scan_number(c);
      end
      // overlong line: this character is dropped and the line starts over
      if (pos + 1 >= ascp_pkg::LINE_LEN) begin
        clear_line();
        r.st   = ascp_pkg::ST_TOO_LONG;
        r.freq = tgt_freq;
        r.md   = out_sel;
        due_status_q.push_back(r);
      end else begin
        pos++;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    line_status_t due;
    if (rst) begin
      due_status_q.delete();
      tgt_freq = '0;
      out_sel  = '0;
      clear_line();
    end else begin
      if (in_valid && !in_stall) begin
        taken++;
        parse_char(rx_byte);
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (due_status_q.size() == 0) begin
          if (errs < 10)
            $display("%0t: status item %0d with nothing due: status=%0d freq=%0d mode=%0d",
                     $realtime, checked, status, frequency, mode);
          errs++;
        end else begin
          due = due_status_q.pop_front();
          if (status !== due.st || frequency !== due.freq || mode !== due.md) begin
            if (errs < 10)
              $display("%0t: status item %0d: got status=%0d freq=%0d mode=%0d, %s %0d %0d %0d",
                       $realtime, checked, status, frequency, mode,
                       "want", due.st, due.freq, due.md);
            errs++;
          end
        end
      end
    end
    fail_count   <= errs;
    pending      <= due_status_q.size();
    bytes_taken  <= taken;
    results_seen <= checked;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the command parser directed command lines and then random lines
// (well-formed commands with random numbers, broken prefixes, noise and
// overlong lines) under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_style_t;

  localparam int RANDOM_BYTES = 1450;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [13:0] frequency;
  logic [1:0]  mode;

  int fail_count;
  int pending;
  int bytes_taken;
  int results_seen;

  stall_style_t stall_style = STALL_NONE;
  logic [15:0]  stall_tick  = '0;

  logic [7:0] line_q[$];
  int         burst_left = 0;
  int         bytes_sent = 0;
  int         lines_sent = 0;

  ascii_setting_command_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .frequency (frequency),
    .mode      (mode)
  );

  ascp_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .frequency    (frequency),
    .mode         (mode),
    .fail_count   (fail_count),
    .pending      (pending),
    .bytes_taken  (bytes_taken),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL ascii_setting_command_parser");
    $finish;
  end

  // receiver stall pattern, restyled whenever stall_tick[6:0] wraps to zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick[6:0] == 7'd0) stall_style <= stall_style_t'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_tick[3];
    endcase
  end

  task automatic send_char(input logic [7:0] c);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    rx_byte  <= c;
    do @(posedge clk); while (in_stall);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_any_prefix();
    if ($urandom_range(0, 1)) push_text("Target Frequency ");
    else push_text("Output Mode ");
  endtask

  function automatic logic [7:0] pick_term();
    return $urandom_range(0, 1) ? ascp_pkg::CH_CR : ascp_pkg::CH_LF;
  endfunction

  // any byte except a line terminator
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == ascp_pkg::CH_CR || b == ascp_pkg::CH_LF) b = b | 8'h80;
    return b;
  endfunction

  task automatic send_line(input logic [7:0] term);
    foreach (line_q[i]) send_char(line_q[i]);
    send_char(term);
    line_q.delete();
    lines_sent++;
  endtask

  task automatic push_number(input int lim);
    int v;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
      case ($urandom_range(0, 3))
        0:       line_q.push_back(ascp_pkg::CH_TAB);
        1:       line_q.push_back(ascp_pkg::CH_VT);
        2:       line_q.push_back(ascp_pkg::CH_FF);
        default: line_q.push_back(ascp_pkg::CH_SPACE);
      endcase
    end
    case ($urandom_range(0, 19))
      0, 1, 2: line_q.push_back(ascp_pkg::CH_MINUS);
      3, 4:    line_q.push_back(ascp_pkg::CH_PLUS);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) push_text("00");
    case ($urandom_range(0, 9))
      0:       v = -1;
      1:       v = $urandom_range(10001, 99999999);
      2:       v = ($urandom_range(0, 1) ? lim : lim + 1);
      3:       v = $urandom_range(0, 1);
      default: v = $urandom_range(0, lim + 1);
    endcase
    if (v >= 0) push_text($sformatf("%0d", v));
    if ($urandom_range(0, 4) == 0) line_q.push_back(plain_byte());
  endtask

  task automatic build_random_line();
    int k;
    int n;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      push_text("Target Frequency ");
      push_number(ascp_pkg::FREQ_MAX);
    end else if (k < 65) begin
      push_text("Output Mode ");
      push_number(ascp_pkg::MODE_MAX);
    end else if (k < 75) begin
      // one prefix character replaced
      push_any_prefix();
      n = $urandom_range(0, line_q.size() - 1);
      line_q[n] = plain_byte();
      push_number(ascp_pkg::FREQ_MAX);
    end else if (k < 83) begin
      // prefix cut short
      push_any_prefix();
      n = $urandom_range(0, line_q.size() - 1);
      while (line_q.size() > n) void'(line_q.pop_back());
      if ($urandom_range(0, 1)) push_text($sformatf("%0d", $urandom_range(0, 9)));
    end else if (k < 93) begin
      repeat ($urandom_range(0, 20)) line_q.push_back(plain_byte());
    end else begin
      if ($urandom_range(0, 1)) push_text("Target Frequency ");
      n = $urandom_range(ascp_pkg::LINE_LEN - 4, ascp_pkg::LINE_LEN + 12);
      while (line_q.size() < n) begin
        if ($urandom_range(0, 1)) line_q.push_back(8'($urandom_range(48, 57)));
        else line_q.push_back(8'($urandom_range(32, 126)));
      end
    end
    send_line(pick_term());
  endtask

  initial begin : stimulus
    int start;
    int drain;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines: range edges, signs, blanks, short and overlong lines
    push_text("Target Frequency 0");          send_line(ascp_pkg::CH_LF);
    push_text("Target Frequency 10000");      send_line(ascp_pkg::CH_CR);
    push_text("Target Frequency 10001");      send_line(ascp_pkg::CH_LF);
    push_text("Target Frequency 99999999");   send_line(ascp_pkg::CH_LF);
    push_text("Target Frequency -0");         send_line(ascp_pkg::CH_CR);
    push_text("Target Frequency -5");         send_line(ascp_pkg::CH_LF);
    push_text("Target Frequency +123");       send_line(ascp_pkg::CH_LF);
    push_text("Target Frequency ");           send_line(ascp_pkg::CH_CR);
    push_text("Target Frequency \t 42abc");   send_line(ascp_pkg::CH_LF);
    push_text("Target Frequency x12");        send_line(ascp_pkg::CH_LF);
    push_text("Output Mode 1");               send_line(ascp_pkg::CH_LF);
    push_text("Output Mode 2");               send_line(ascp_pkg::CH_CR);
    push_text("Output Mode 3");               send_line(ascp_pkg::CH_LF);
    push_text("Output Mode 0");               send_line(ascp_pkg::CH_LF);
    push_text("Output Mode 4");               send_line(ascp_pkg::CH_LF);
    push_text("Output Mode -1");              send_line(ascp_pkg::CH_LF);
    push_text("Output Mode -0");              send_line(ascp_pkg::CH_LF);
    push_text("Output Mode ");                send_line(ascp_pkg::CH_LF);
    push_text("Output Mode");                 send_line(ascp_pkg::CH_LF);
    push_text("Target");                      send_line(ascp_pkg::CH_CR);
    send_line(ascp_pkg::CH_LF);
    line_q.push_back(ascp_pkg::CH_VT);
    line_q.push_back(8'h00);
    line_q.push_back(8'hff);
    push_text("Output Mode +2");
    send_line(ascp_pkg::CH_CR);
    // 63 stored characters still fit in a line
    push_text("Target Frequency ");
    while (line_q.size() < ascp_pkg::LINE_LEN - 1) line_q.push_back(ascp_pkg::CH_ZERO);
    send_line(ascp_pkg::CH_LF);
    // one more overflows and restarts the line
    push_text("Target Frequency ");
    while (line_q.size() < ascp_pkg::LINE_LEN + 6) line_q.push_back(8'h37);
    send_line(ascp_pkg::CH_LF);

    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) build_random_line();
    in_valid <= 1'b0;

    @(posedge clk);
    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);

    $display("sent %0d lines in %0d characters (%0d accepted)",
             lines_sent, bytes_sent, bytes_taken);
    $display("checked %0d status items, %0d mismatches, %0d still due",
             results_seen, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS ascii_setting_command_parser");
    end else begin
      $display("FAIL ascii_setting_command_parser");
    end
    $finish;
  end

endmodule
